// ===== hw/rtl/cpualu_pkg.sv =====
// Shared types and constants for the CPU ALU with decimal adjust.
`default_nettype none
package cpualu_pkg;

  typedef enum logic [4:0] {
    ACT_ADD    = 5'd0,
    ACT_ADC    = 5'd1,
    ACT_SUB    = 5'd2,
    ACT_SBC    = 5'd3,
    ACT_AND    = 5'd4,
    ACT_XOR    = 5'd5,
    ACT_OR     = 5'd6,
    ACT_CP     = 5'd7,
    ACT_INC    = 5'd8,
    ACT_DEC    = 5'd9,
    ACT_DAA    = 5'd10,
    ACT_CPL    = 5'd11,
    ACT_SCF    = 5'd12,
    ACT_CCF    = 5'd13,
    ACT_RLCA   = 5'd14,
    ACT_RLA    = 5'd15,
    ACT_RRCA   = 5'd16,
    ACT_RRA    = 5'd17,
    ACT_RLC    = 5'd18,
    ACT_RRC    = 5'd19,
    ACT_RL     = 5'd20,
    ACT_RR     = 5'd21,
    ACT_SLA    = 5'd22,
    ACT_SRA    = 5'd23,
    ACT_SWAP   = 5'd24,
    ACT_SRL    = 5'd25,
    ACT_ADD16  = 5'd26,
    ACT_ADDSP  = 5'd27
  } action_t;

  localparam logic [7:0] DAA_LIMIT    = 8'h99;
  localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
  localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
  localparam logic [3:0] DAA_NIB_MAX  = 4'h9;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] a;
    logic [15:0] b;
    flags_t      flags;
  } op_t;

  typedef struct packed {
    logic [15:0] result;
    flags_t      flags;
  } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cpualu_core.sv =====
// Combinational datapath of the ALU: one operation to result and flags.
`default_nettype none
module cpualu_core (
  input  wire cpualu_pkg::op_t op,
  output cpualu_pkg::res_t     res
);
  import cpualu_pkg::*;

  logic [7:0]  a;
  logic [7:0]  b;
  logic        ci;
  logic        cy;
  logic [8:0]  sum9;
  logic [4:0]  hsum;
  logic [8:0]  diff9;
  logic [4:0]  hdiff;
  logic [7:0]  r8;
  logic [7:0]  daa_val;
  logic        daa_c;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [15:0] sp_ext;
  logic [8:0]  sp_sum9;
  logic [4:0]  sp_hsum;

  always_comb begin
    a  = op.a[7:0];
    b  = op.b[7:0];
    ci = op.flags.c;
    cy = ((op.action == ACT_ADC) || (op.action == ACT_SBC)) ? ci : 1'b0;

    sum9  = {1'b0, a} + {1'b0, b} + {8'd0, cy};
    hsum  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cy};
    diff9 = {1'b0, a} - {1'b0, b} - {8'd0, cy};
    hdiff = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cy};

    // Decimal adjust: high correction first, then low on the corrected value
    daa_c = ci;
    if (op.flags.n) begin
      daa_val = a - (ci ? DAA_HIGH_ADJ : 8'h00) - (op.flags.h ? DAA_LOW_ADJ : 8'h00);
    end else begin
      daa_val = a;
      if (ci || (a > DAA_LIMIT)) begin
        daa_val = a + DAA_HIGH_ADJ;
        daa_c   = 1'b1;
      end
      if (op.flags.h || (daa_val[3:0] > DAA_NIB_MAX)) begin
        daa_val = daa_val + DAA_LOW_ADJ;
      end
    end

    sum17   = {1'b0, op.a} + {1'b0, op.b};
    sum13   = {1'b0, op.a[11:0]} + {1'b0, op.b[11:0]};
    sp_ext  = {{8{b[7]}}, b};
    sp_sum9 = {1'b0, a} + {1'b0, b};
    sp_hsum = {1'b0, a[3:0]} + {1'b0, b[3:0]};

    r8         = 8'd0;
    res.result = op.a;
    res.flags  = op.flags;

    case (op.action)
      ACT_ADD, ACT_ADC: begin
        r8        = sum9[7:0];
        res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: hsum[4], c: sum9[8]};
        res.result = {8'd0, r8};
      end
      ACT_SUB, ACT_SBC, ACT_CP: begin
        r8        = diff9[7:0];
        res.flags = '{z: (r8 == 8'd0), n: 1'b1, h: hdiff[4], c: diff9[8]};
        res.result = (op.action == ACT_CP) ? op.a : {8'd0, r8};
      end
      ACT_AND: begin
        r8         = a & b;
        res.flags  = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
        res.result = {8'd0, r8};
      end
      ACT_XOR: begin
        r8         = a ^ b;
        res.flags  = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
        res.result = {8'd0, r8};
      end
      ACT_OR: begin
        r8         = a | b;
        res.flags  = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
        res.result = {8'd0, r8};
      end
      ACT_INC: begin
        r8         = a + 8'd1;
        res.flags  = '{z: (r8 == 8'd0), n: 1'b0, h: (a[3:0] == 4'hF), c: ci};
        res.result = {8'd0, r8};
      end
      ACT_DEC: begin
        r8         = a - 8'd1;
        res.flags  = '{z: (r8 == 8'd0), n: 1'b1, h: (a[3:0] == 4'h0), c: ci};
        res.result = {8'd0, r8};
      end
      ACT_DAA: begin
        r8         = daa_val;
        res.flags  = '{z: (r8 == 8'd0), n: op.flags.n, h: 1'b0, c: daa_c};
        res.result = {8'd0, r8};
      end
      ACT_CPL: begin
        res.flags  = '{z: op.flags.z, n: 1'b1, h: 1'b1, c: ci};
        res.result = {8'd0, ~a};
      end
      ACT_SCF: begin
        res.flags = '{z: op.flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      ACT_CCF: begin
        res.flags = '{z: op.flags.z, n: 1'b0, h: 1'b0, c: ~ci};
      end
      ACT_RLCA, ACT_RLC: begin
        r8         = {a[6:0], a[7]};
        res.flags  = '{z: (op.action == ACT_RLC) && (r8 == 8'd0), n: 1'b0, h: 1'b0,
                       c: a[7]};
        res.result = {8'd0, r8};
      end
      ACT_RLA, ACT_RL: begin
        r8         = {a[6:0], ci};
        res.flags  = '{z: (op.action == ACT_RL) && (r8 == 8'd0), n: 1'b0, h: 1'b0,
                       c: a[7]};
        res.result = {8'd0, r8};
      end
      ACT_RRCA, ACT_RRC: begin
        r8         = {a[0], a[7:1]};
        res.flags  = '{z: (op.action == ACT_RRC) && (r8 == 8'd0), n: 1'b0, h: 1'b0,
                       c: a[0]};
        res.result = {8'd0, r8};
      end
      ACT_RRA, ACT_RR: begin
        r8         = {ci, a[7:1]};
        res.flags  = '{z: (op.action == ACT_RR) && (r8 == 8'd0), n: 1'b0, h: 1'b0,
                       c: a[0]};
        res.result = {8'd0, r8};
      end
      ACT_SLA: begin
        r8         = {a[6:0], 1'b0};
        res.flags  = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
        res.result = {8'd0, r8};
      end
      ACT_SRA: begin
        r8         = {a[7], a[7:1]};
        res.flags  = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
        res.result = {8'd0, r8};
      end
      ACT_SWAP: begin
        r8         = {a[3:0], a[7:4]};
        res.flags  = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
        res.result = {8'd0, r8};
      end
      ACT_SRL: begin
        r8         = {1'b0, a[7:1]};
        res.flags  = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
        res.result = {8'd0, r8};
      end
      ACT_ADD16: begin
        res.flags  = '{z: op.flags.z, n: 1'b0, h: sum13[12], c: sum17[16]};
        res.result = sum17[15:0];
      end
      ACT_ADDSP: begin
        res.flags  = '{z: 1'b0, n: 1'b0, h: sp_hsum[4], c: sp_sum9[8]};
        res.result = op.a + sp_ext;
      end
      default: begin
        // unused codes: pass operand and flags through
        res.result = op.a;
        res.flags  = op.flags;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cpu_alu_with_bcd_adjust.sv =====
// Top level of the CPU ALU: input register, ALU datapath, result register.
// Usage
//   Input channel: drive in_valid with action, operand_a, operand_b and the
//   four incoming flags. A beat is taken at a rising edge of clk where
//   in_valid is high and in_stall is low.
//   Output channel: out_valid marks a result beat on result and the four new
//   flags; the beat is delivered at an edge where out_stall is low.
//   Every operation gives exactly one result beat, in issue order.
// Latency and throughput
//   A taken beat passes through two register stages (input register, then
//   result register) before it is shown on the outputs. One beat per
//   cycle is sustained while out_stall is low; the combinational ALU datapath
//   between the two registers sets that figure.
// Stall
//   While the receiver stalls, the result register holds its beat and the
//   input register holds the next one; in_stall rises only when both are
//   full, so two beats are buffered before the sender is held.
// Reset
//   rst (synchronous, active high) empties both stages. The ALU keeps no
//   other state, so nothing else needs clearing.
`default_nettype none
module cpu_alu_with_bcd_adjust (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [4:0]  action,
  input  wire logic [15:0] operand_a,
  input  wire logic [15:0] operand_b,
  input  wire logic        zero_in,
  input  wire logic        sub_in,
  input  wire logic        half_in,
  input  wire logic        carry_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      result,
  output logic             zero_out,
  output logic             sub_out,
  output logic             half_out,
  output logic             carry_out
);
  import cpualu_pkg::*;

  logic   s1_valid;
  op_t    s1_op;
  res_t   alu_res;
  res_t   out_res;
  logic   out_load;
  logic   s1_load;

  // Result register takes a new beat when empty or when its beat leaves now
  assign out_load = !out_valid || !out_stall;
  // Input register advances with the result register, or fills when empty
  assign s1_load  = !s1_valid || out_load;
  assign in_stall = !s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= in_valid;
    end
  end

  // Payload: hold while stalled, no reset needed
  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_op <= '{action: action_t'(action), a: operand_a, b: operand_b,
                 flags: '{z: zero_in, n: sub_in, h: half_in, c: carry_in}};
    end
  end

  cpualu_core u_core (
    .op  (s1_op),
    .res (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      out_res <= alu_res;
    end
  end

  assign result    = out_res.result;
  assign zero_out  = out_res.flags.z;
  assign sub_out   = out_res.flags.n;
  assign half_out  = out_res.flags.h;
  assign carry_out = out_res.flags.c;

  // An accepted beat always lands in the input register
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> s1_valid)
    else $error("accepted beat lost before input register");

  // A waiting beat moves into an empty result register
  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_valid) |=> out_valid)
    else $error("beat not advanced into empty result register");

  // With nothing behind it, a delivered result is not shown again
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !s1_valid) |=> !out_valid)
    else $error("result beat repeated");

  // The sender is held only while both stages are full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled with free buffer space");

endmodule
`default_nettype wire

// ===== dv/cpu_alu_checker.sv =====
// Scoreboard for the CPU ALU: predicts each input beat and checks each result beat.
module cpu_alu_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [4:0]        action,
  input  logic [15:0]       operand_a,
  input  logic [15:0]       operand_b,
  input  logic              zero_in,
  input  logic              sub_in,
  input  logic              half_in,
  input  logic              carry_in,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [15:0]       result,
  input  logic              zero_out,
  input  logic              sub_out,
  input  logic              half_out,
  input  logic              carry_out,
  output int unsigned       mismatch_cnt,
  output int unsigned       pending_cnt,
  output int unsigned       checked_cnt,
  output bit [31:0]         ops_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import cpualu_pkg::*;

  localparam int unsigned MAX_LOGGED = 200;

  typedef struct {
    res_t        want;
    logic [4:0]  act;
  } alu_expect_t;

  alu_expect_t alu_expect_q[$];

  function automatic res_t alu_res(input logic [15:0] r, input logic z, input logic n,
                                   input logic h, input logic c);
    res_t o;
    o.result = r;
    o.flags  = flags_t'({z, n, h, c});
    return o;
  endfunction

  // Work out the result and new flags of one operation.
  function automatic res_t alu_predict(input logic [4:0] act, input logic [15:0] a16,
                                       input logic [15:0] b16, input flags_t fin);
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  r;
    logic        cy;
    logic [4:0]  s5;
    logic [8:0]  s9;
    logic [12:0] s13;
    logic [16:0] s17;
    a = a16[7:0];
    b = b16[7:0];
    case (act)
      ACT_ADD, ACT_ADC: begin
        cy  = (act == ACT_ADC) ? fin.c : 1'b0;
        s9  = {1'b0, a} + {1'b0, b} + 9'(cy);
        s5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + 5'(cy);
        return alu_res({8'h00, s9[7:0]}, s9[7:0] == 8'h00, 1'b0, s5[4], s9[8]);
      end
      ACT_SUB, ACT_SBC, ACT_CP: begin
        cy  = (act == ACT_SBC) ? fin.c : 1'b0;
        r   = a - b - 8'(cy);
        s5  = {1'b0, b[3:0]} + 5'(cy);
        s9  = {1'b0, b} + 9'(cy);
        return alu_res((act == ACT_CP) ? a16 : {8'h00, r}, r == 8'h00, 1'b1,
                       {1'b0, a[3:0]} < s5, {1'b0, a} < s9);
      end
      ACT_AND: begin
        r = a & b;
        return alu_res({8'h00, r}, r == 8'h00, 1'b0, 1'b1, 1'b0);
      end
      ACT_XOR: begin
        r = a ^ b;
        return alu_res({8'h00, r}, r == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      ACT_OR: begin
        r = a | b;
        return alu_res({8'h00, r}, r == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      ACT_INC: begin
        r = a + 8'd1;
        return alu_res({8'h00, r}, r == 8'h00, 1'b0, a[3:0] == 4'hF, fin.c);
      end
      ACT_DEC: begin
        r = a - 8'd1;
        return alu_res({8'h00, r}, r == 8'h00, 1'b1, a[3:0] == 4'h0, fin.c);
      end
      ACT_DAA: begin
        r  = a;
        cy = fin.c;
        if (fin.n) begin
          if (fin.c) r = r - DAA_HIGH_ADJ;
          if (fin.h) r = r - DAA_LOW_ADJ;
        end else begin
          if (fin.c || r > DAA_LIMIT) begin
            r  = r + DAA_HIGH_ADJ;
            cy = 1'b1;
          end
          if (fin.h || r[3:0] > DAA_NIB_MAX) r = r + DAA_LOW_ADJ;
        end
        return alu_res({8'h00, r}, r == 8'h00, fin.n, 1'b0, cy);
      end
      ACT_CPL:  return alu_res({8'h00, ~a}, fin.z, 1'b1, 1'b1, fin.c);
      ACT_SCF:  return alu_res(a16, fin.z, 1'b0, 1'b0, 1'b1);
      ACT_CCF:  return alu_res(a16, fin.z, 1'b0, 1'b0, ~fin.c);
      ACT_RLCA, ACT_RLC: begin
        r = {a[6:0], a[7]};
        return alu_res({8'h00, r}, (act == ACT_RLC) && r == 8'h00, 1'b0, 1'b0, a[7]);
      end
      ACT_RLA, ACT_RL: begin
        r = {a[6:0], fin.c};
        return alu_res({8'h00, r}, (act == ACT_RL) && r == 8'h00, 1'b0, 1'b0, a[7]);
      end
      ACT_RRCA, ACT_RRC: begin
        r = {a[0], a[7:1]};
        return alu_res({8'h00, r}, (act == ACT_RRC) && r == 8'h00, 1'b0, 1'b0, a[0]);
      end
      ACT_RRA, ACT_RR: begin
        r = {fin.c, a[7:1]};
        return alu_res({8'h00, r}, (act == ACT_RR) && r == 8'h00, 1'b0, 1'b0, a[0]);
      end
      ACT_SLA: begin
        r = {a[6:0], 1'b0};
        return alu_res({8'h00, r}, r == 8'h00, 1'b0, 1'b0, a[7]);
      end
      ACT_SRA: begin
        r = {a[7], a[7:1]};
        return alu_res({8'h00, r}, r == 8'h00, 1'b0, 1'b0, a[0]);
      end
      ACT_SWAP: begin
        r = {a[3:0], a[7:4]};
        return alu_res({8'h00, r}, r == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      ACT_SRL: begin
        r = {1'b0, a[7:1]};
        return alu_res({8'h00, r}, r == 8'h00, 1'b0, 1'b0, a[0]);
      end
      ACT_ADD16: begin
        s17 = {1'b0, a16} + {1'b0, b16};
        s13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
        return alu_res(s17[15:0], fin.z, 1'b0, s13[12], s17[16]);
      end
      ACT_ADDSP: begin
        // flags from the unsigned low-byte sum, result from the sign-extended one
        s9 = {1'b0, a} + {1'b0, b};
        s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]};
        return alu_res(a16 + {{8{b[7]}}, b}, 1'b0, 1'b0, s5[4], s9[8]);
      end
      default:  return alu_res(a16, fin.z, fin.n, fin.h, fin.c);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatch_cnt < MAX_LOGGED)
      $display("[%0t] MISMATCH %s: got %h, expected %h (result beat %0d)",
               $realtime, what, got, want, checked_cnt);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin
    alu_expect_t head;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (alu_expect_q.size() == 0) begin
          report_mismatch("result beat with nothing expected", result, 16'h0000);
        end else begin
          head = alu_expect_q.pop_front();
          if (result !== head.want.result)
            report_mismatch($sformatf("result (action %0d)", head.act), result,
                            head.want.result);
          if (zero_out !== head.want.flags.z)
            report_mismatch($sformatf("Z (action %0d)", head.act), 16'(zero_out),
                            16'(head.want.flags.z));
          if (sub_out !== head.want.flags.n)
            report_mismatch($sformatf("N (action %0d)", head.act), 16'(sub_out),
                            16'(head.want.flags.n));
          if (half_out !== head.want.flags.h)
            report_mismatch($sformatf("H (action %0d)", head.act), 16'(half_out),
                            16'(head.want.flags.h));
          if (carry_out !== head.want.flags.c)
            report_mismatch($sformatf("C (action %0d)", head.act), 16'(carry_out),
                            16'(head.want.flags.c));
          checked_cnt++;
        end
      end
      if (in_valid && !in_stall) begin
        alu_expect_q.push_back('{want: alu_predict(action, operand_a, operand_b,
                                                   flags_t'({zero_in, sub_in, half_in,
                                                             carry_in})),
                                 act: action});
        ops_seen[action] = 1'b1;
      end
    end
    pending_cnt <= alu_expect_q.size();
  end

endmodule

// ===== dv/cpu_alu_with_bcd_adjust_tb.sv =====
// Testbench top for the CPU ALU: clock, reset, stimulus phases and the verdict.
module cpu_alu_with_bcd_adjust_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cpualu_pkg::*;

  // Leave a wide margin over the slowest sane run.
  localparam int unsigned CYCLE_LIMIT   = 200_000;
  localparam int unsigned HOLD_CYCLES   = 60;
  localparam int unsigned DRAIN_CYCLES  = 10;
  localparam logic [4:0]  ACT_CODE_MAX  = 5'd31;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [4:0]  action    = '0;
  logic [15:0] operand_a = '0;
  logic [15:0] operand_b = '0;
  logic        zero_in   = 1'b0;
  logic        sub_in    = 1'b0;
  logic        half_in   = 1'b0;
  logic        carry_in  = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] result;
  logic        zero_out;
  logic        sub_out;
  logic        half_out;
  logic        carry_out;

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned checked_cnt;
  bit [31:0]   ops_seen;

  // Percentages that shape the traffic of the current phase.
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  bit          hold_wanted = 1'b0;
  bit          hold_given  = 1'b0;
  int unsigned items_sent  = 0;
  int unsigned cycle_cnt   = 0;

  cpu_alu_with_bcd_adjust i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .zero_in   (zero_in),
    .sub_in    (sub_in),
    .half_in   (half_in),
    .carry_in  (carry_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result),
    .zero_out  (zero_out),
    .sub_out   (sub_out),
    .half_out  (half_out),
    .carry_out (carry_out)
  );

  cpu_alu_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .zero_in      (zero_in),
    .sub_in       (sub_in),
    .half_in      (half_in),
    .carry_in     (carry_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result       (result),
    .zero_out     (zero_out),
    .sub_out      (sub_out),
    .half_out     (half_out),
    .carry_out    (carry_out),
    .mismatch_cnt (mismatch_cnt),
    .pending_cnt  (pending_cnt),
    .checked_cnt  (checked_cnt),
    .ops_seen     (ops_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Give up if the run hangs; a healthy run ends long before this.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_cnt, pending_cnt);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: stall at random per phase. Once the pressure phase asks for it,
  // hold off for a long stretch so both pipeline stages fill and in_stall rises.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_wanted && !hold_given) begin
        hold_given = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Offer one beat and hold it until it is taken. Idle cycles come first, so
  // a stalled payload never changes and valid never looks at stall.
  task automatic send_op(input logic [4:0] act, input logic [15:0] a, input logic [15:0] b,
                         input logic [3:0] znhc);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    operand_a <= a;
    operand_b <= b;
    {zero_in, sub_in, half_in, carry_in} <= znhc;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Operands lean towards the corners: all zeros, all ones, BCD and nibble limits.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return {8'($urandom), 8'h99};
      3:       return {8'($urandom), 4'($urandom), 4'hF};
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly real operations; now and then one of the unused codes.
  function automatic logic [4:0] pick_action();
    if ($urandom_range(0, 19) == 0)
      return 5'($urandom_range(int'(ACT_ADDSP) + 1, int'(ACT_CODE_MAX)));
    return 5'($urandom_range(0, int'(ACT_ADDSP)));
  endfunction

  task automatic run_random(input int unsigned n, input int unsigned idle,
                            input int unsigned stall);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) send_op(pick_action(), pick_word(), pick_word(), 4'($urandom));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed beats, flags given as {Z, N, H, C}. Upper bytes are set on
    // several 8-bit operations to show they are ignored.
    send_op(ACT_ADD,   16'hFFFF, 16'hFF01, 4'b0000);  // wraps to zero, H and C
    send_op(ACT_ADC,   16'h000F, 16'h0000, 4'b0001);  // carry in makes half carry
    send_op(ACT_SUB,   16'h0000, 16'h0001, 4'b0000);  // borrow
    send_op(ACT_SBC,   16'h00FF, 16'h00FF, 4'b0001);  // borrow through carry in
    send_op(ACT_AND,   16'hABF0, 16'hCD0F, 4'b0000);
    send_op(ACT_XOR,   16'h00FF, 16'h00FF, 4'b0000);
    send_op(ACT_OR,    16'h0000, 16'h0000, 4'b1111);
    send_op(ACT_CP,    16'h1234, 16'h0034, 4'b0000);  // A passes through
    send_op(ACT_INC,   16'hFFFF, 16'h0000, 4'b0001);
    send_op(ACT_DEC,   16'h0000, 16'hFFFF, 4'b0000);
    send_op(ACT_DAA,   16'h009A, 16'h0000, 4'b0000);  // above 0x99 after add
    send_op(ACT_DAA,   16'h0000, 16'h0000, 4'b0011);  // both adjusts after add
    send_op(ACT_DAA,   16'h0000, 16'h0000, 4'b0111);  // both adjusts after sub
    send_op(ACT_CPL,   16'hFF5A, 16'h0000, 4'b1001);
    send_op(ACT_SCF,   16'hBEEF, 16'h0000, 4'b1110);
    send_op(ACT_CCF,   16'hCAFE, 16'h0000, 4'b0001);
    send_op(ACT_RLCA,  16'h0080, 16'h0000, 4'b1110);  // Z stays clear
    send_op(ACT_RLA,   16'h0080, 16'h0000, 4'b0000);  // zero result, Z still clear
    send_op(ACT_RRCA,  16'h0001, 16'h0000, 4'b0000);
    send_op(ACT_RRA,   16'h0001, 16'h0000, 4'b0001);
    send_op(ACT_RLC,   16'hFF00, 16'h0000, 4'b0000);
    send_op(ACT_RRC,   16'h0001, 16'h0000, 4'b0000);
    send_op(ACT_RL,    16'h0080, 16'h0000, 4'b0000);  // carry from bit 7
    send_op(ACT_RR,    16'h0001, 16'h0000, 4'b0000);
    send_op(ACT_SLA,   16'h0080, 16'h0000, 4'b0000);
    send_op(ACT_SRA,   16'h0081, 16'h0000, 4'b0000);
    send_op(ACT_SWAP,  16'h00F0, 16'h0000, 4'b0000);
    send_op(ACT_SRL,   16'h0001, 16'h0000, 4'b0000);  // Z from own result
    send_op(ACT_ADD16, 16'hFFFF, 16'h0001, 4'b1000);  // Z kept from input
    send_op(ACT_ADDSP, 16'hFFF8, 16'h0008, 4'b1111);  // flags from low byte
    send_op(ACT_ADDSP, 16'h0000, 16'h00FF, 4'b0000);  // negative offset
    send_op(ACT_CODE_MAX, 16'h5A5A, 16'hA5A5, 4'b1010);

    // Random traffic: clean, sender idling, receiver stalling, both.
    run_random(200, 0, 0);
    run_random(200, 74, 0);
    run_random(200, 0, 74);
    run_random(200, 34, 34);

    // Back-pressure: receiver holds off while the sender keeps pushing.
    hold_wanted = 1'b1;
    run_random(200, 0, 0);
    in_valid <= 1'b0;

    // Drain, then allow the pipeline latency to show any stray beat.
    do @(posedge clk); while (pending_cnt != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d operations over %0d action codes, with idle, stall and hold-off phases",
             items_sent, $countones(ops_seen));
    $display("Checked %0d result beats, %0d mismatches", checked_cnt, mismatch_cnt);
    if (mismatch_cnt == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
